// ===== hdl/lifn_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lifn_pkg: shared types, constants and helpers for the LIF neuron step
// Word formats, register map, reset values and saturation used by the core.
// ----------------------------------------------------------------------------
package lifn_pkg;

	localparam int DATA_W    = 32;          // Q16.16 states, Q8.24 coefficients
	localparam int PROD_W    = 2 * DATA_W;  // exact product
	localparam int COEF_FRAC = 24;          // fraction bits of a coefficient
	localparam int ACC_W     = PROD_W - COEF_FRAC;
	localparam int REFR_W    = 16;
	localparam int ADDR_W    = 5;           // eight 32-bit registers
	localparam int REFR_STEPS_DEF = 20;

	localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	localparam logic signed [DATA_W-1:0] SYN_DECAY_RST      = 32'sd16609070;
	localparam logic signed [DATA_W-1:0] SYN_COUPLE_RST     = 32'sd1660907;
	localparam logic signed [DATA_W-1:0] CURRENT_GAIN_RST   = 32'sd6678;
	localparam logic signed [DATA_W-1:0] SYN1_GAIN_RST      = 32'sd0;
	localparam logic signed [DATA_W-1:0] SYN2_GAIN_RST      = 32'sd0;
	localparam logic signed [DATA_W-1:0] MEMBRANE_DECAY_RST = 32'sd16610142;
	localparam logic signed [DATA_W-1:0] THRESHOLD_RST      = 32'sd983040;
	localparam logic signed [DATA_W-1:0] RESET_LEVEL_RST    = 32'sd0;

	typedef enum logic [2:0] {
		REG_SYN_DECAY      = 3'd0,
		REG_SYN_COUPLE     = 3'd1,
		REG_CURRENT_GAIN   = 3'd2,
		REG_SYN1_GAIN      = 3'd3,
		REG_SYN2_GAIN      = 3'd4,
		REG_MEMBRANE_DECAY = 3'd5,
		REG_THRESHOLD      = 3'd6,
		REG_RESET_LEVEL    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] spike_drive;
		logic signed [DATA_W-1:0] current_in;
	} in_word_t;

	typedef struct packed {
		logic                     spike;
		logic signed [DATA_W-1:0] membrane;
	} out_word_t;

	// clamp a sign-extended value to the 32-bit range
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = {{(ACC_W-DATA_W){Q_MAX[DATA_W-1]}}, Q_MAX};
		lo = {{(ACC_W-DATA_W){Q_MIN[DATA_W-1]}}, Q_MIN};
		if (v > hi) begin
			return Q_MAX;
		end else if (v < lo) begin
			return Q_MIN;
		end else begin
			return v[DATA_W-1:0];
		end
	endfunction

endpackage
`default_nettype wire

// ===== hdl/lifn_mulq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lifn_mulq: Q8.24 x Q16.16 multiply with rounding and saturation
// Exact product, round half up at bit 23, arithmetic shift by 24, clamp.
// ----------------------------------------------------------------------------
module lifn_mulq (
	input  wire logic signed [lifn_pkg::DATA_W-1:0] coef,
	input  wire logic signed [lifn_pkg::DATA_W-1:0] val,
	output logic signed [lifn_pkg::DATA_W-1:0]      res
);

	localparam int PW = lifn_pkg::PROD_W;
	localparam int CF = lifn_pkg::COEF_FRAC;

	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] rnd;

	always_comb begin
		prod = PW'(coef) * PW'(val);
		rnd  = prod + {{(PW-CF){1'b0}}, 1'b1, {(CF-1){1'b0}}};
		// upper bits of the rounded product are the floor shift
		res  = lifn_pkg::sat32(rnd[PW-1:CF]);
	end

endmodule
`default_nettype wire

// ===== hdl/lif_neuron_alpha_synapse_step_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lif_neuron_alpha_synapse_step_top: LIF neuron with alpha synapse, one tick
// Input register, combinational state update, output register, APB registers.
// ----------------------------------------------------------------------------
// One word in is one simulation tick of a leaky integrate-and-fire neuron with
// alpha-shaped synaptic current; one word out (spike flag, membrane) follows
// per tick, in order. The state update (seven parallel 32x32 multiplies,
// rounding, saturating sums, threshold compare) is combinational between
// the input register and the result register; a new word is taken every
// cycle unless the result register is full and result_ready is low. The
// neuron state lives in the block; it is cleared by reset. Propagators and
// levels are written over APB at byte address 4*index; the user must do so
// only while no word is in flight, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module lif_neuron_alpha_synapse_step_top #(
	parameter int unsigned REFRACTORY_STEPS = lifn_pkg::REFR_STEPS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           item_valid,
	output logic                                item_ready,
	input  wire lifn_pkg::in_word_t             item,
	output logic                                result_valid,
	input  wire logic                           result_ready,
	output lifn_pkg::out_word_t                 result,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [lifn_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [lifn_pkg::DATA_W-1:0]    pwdata,
	output logic [lifn_pkg::DATA_W-1:0]         prdata,
	output logic                                pready
);

	localparam int DW = lifn_pkg::DATA_W;
	localparam int RW = lifn_pkg::REFR_W;
	localparam int AW = lifn_pkg::ACC_W;
	localparam logic [RW-1:0] REFR_LOAD = RW'(REFRACTORY_STEPS);

	// configuration registers
	logic signed [DW-1:0] syn_decay_q, syn_couple_q, current_gain_q, syn1_gain_q;
	logic signed [DW-1:0] syn2_gain_q, membrane_decay_q, threshold_q, reset_level_q;

	// neuron state
	logic signed [DW-1:0] held_current_q, syn_first_q, syn_second_q, mem_q;
	logic [RW-1:0]        refr_q;

	// handshake / pipeline
	logic                 valid_s1;
	lifn_pkg::in_word_t   item_s1;
	logic                 result_valid_q;
	lifn_pkg::out_word_t  result_q;
	logic                 advance;

	// datapath
	logic signed [DW-1:0] p_cur, p_y1, p_y2, p_mem, p_couple, p_dec2, p_dec1;
	logic signed [DW+1:0] mem_sum;
	logic signed [DW:0]   syn2_sum, syn1_sum;
	logic signed [DW-1:0] mem_int, mem_next, syn1_next, syn2_next;
	logic                 refr_zero, fire;
	logic [RW-1:0]        refr_next;

	lifn_pkg::reg_idx_t   reg_idx;
	logic                 cfg_wr;

	// ---------------- APB register file ----------------
	assign pready  = 1'b1;
	assign reg_idx = lifn_pkg::reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			syn_decay_q      <= lifn_pkg::SYN_DECAY_RST;
			syn_couple_q     <= lifn_pkg::SYN_COUPLE_RST;
			current_gain_q   <= lifn_pkg::CURRENT_GAIN_RST;
			syn1_gain_q      <= lifn_pkg::SYN1_GAIN_RST;
			syn2_gain_q      <= lifn_pkg::SYN2_GAIN_RST;
			membrane_decay_q <= lifn_pkg::MEMBRANE_DECAY_RST;
			threshold_q      <= lifn_pkg::THRESHOLD_RST;
			reset_level_q    <= lifn_pkg::RESET_LEVEL_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				lifn_pkg::REG_SYN_DECAY:      syn_decay_q      <= pwdata;
				lifn_pkg::REG_SYN_COUPLE:     syn_couple_q     <= pwdata;
				lifn_pkg::REG_CURRENT_GAIN:   current_gain_q   <= pwdata;
				lifn_pkg::REG_SYN1_GAIN:      syn1_gain_q      <= pwdata;
				lifn_pkg::REG_SYN2_GAIN:      syn2_gain_q      <= pwdata;
				lifn_pkg::REG_MEMBRANE_DECAY: membrane_decay_q <= pwdata;
				lifn_pkg::REG_THRESHOLD:      threshold_q      <= pwdata;
				lifn_pkg::REG_RESET_LEVEL:    reset_level_q    <= pwdata;
				default:                      syn_decay_q      <= syn_decay_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			lifn_pkg::REG_SYN_DECAY:      prdata = syn_decay_q;
			lifn_pkg::REG_SYN_COUPLE:     prdata = syn_couple_q;
			lifn_pkg::REG_CURRENT_GAIN:   prdata = current_gain_q;
			lifn_pkg::REG_SYN1_GAIN:      prdata = syn1_gain_q;
			lifn_pkg::REG_SYN2_GAIN:      prdata = syn2_gain_q;
			lifn_pkg::REG_MEMBRANE_DECAY: prdata = membrane_decay_q;
			lifn_pkg::REG_THRESHOLD:      prdata = threshold_q;
			lifn_pkg::REG_RESET_LEVEL:    prdata = reset_level_q;
			default:                      prdata = '0;
		endcase
	end

	// ---------------- flow control ----------------
	assign advance      = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready   = !valid_s1 || advance;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
		if (advance) begin
			result_q.spike    <= fire;
			result_q.membrane <= mem_next;
		end
	end

	// ---------------- propagator products ----------------
	lifn_mulq u_mul_cur    (.coef(current_gain_q),   .val(held_current_q), .res(p_cur));
	lifn_mulq u_mul_y1     (.coef(syn1_gain_q),      .val(syn_first_q),    .res(p_y1));
	lifn_mulq u_mul_y2     (.coef(syn2_gain_q),      .val(syn_second_q),   .res(p_y2));
	lifn_mulq u_mul_mem    (.coef(membrane_decay_q), .val(mem_q),          .res(p_mem));
	lifn_mulq u_mul_couple (.coef(syn_couple_q),     .val(syn_first_q),    .res(p_couple));
	lifn_mulq u_mul_dec2   (.coef(syn_decay_q),      .val(syn_second_q),   .res(p_dec2));
	lifn_mulq u_mul_dec1   (.coef(syn_decay_q),      .val(syn_first_q),    .res(p_dec1));

	// ---------------- tick update ----------------
	always_comb begin
		mem_sum  = {{2{p_cur[DW-1]}}, p_cur} + {{2{p_y1[DW-1]}}, p_y1}
		         + {{2{p_y2[DW-1]}}, p_y2} + {{2{p_mem[DW-1]}}, p_mem};
		syn2_sum = {p_couple[DW-1], p_couple} + {p_dec2[DW-1], p_dec2};
		syn1_sum = {p_dec1[DW-1], p_dec1}
		         + {item_s1.spike_drive[DW-1], item_s1.spike_drive};

		syn2_next = lifn_pkg::sat32({{(AW-DW-1){syn2_sum[DW]}}, syn2_sum});
		syn1_next = lifn_pkg::sat32({{(AW-DW-1){syn1_sum[DW]}}, syn1_sum});

		refr_zero = (refr_q == '0);
		// membrane holds while refractory
		mem_int   = refr_zero ? lifn_pkg::sat32({{(AW-DW-2){mem_sum[DW+1]}}, mem_sum})
		                      : mem_q;
		fire      = (mem_int >= threshold_q);
		mem_next  = fire ? reset_level_q : mem_int;

		if (fire) begin
			refr_next = REFR_LOAD;
		end else if (refr_zero) begin
			refr_next = refr_q;
		end else begin
			refr_next = refr_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_current_q <= '0;
			syn_first_q    <= '0;
			syn_second_q   <= '0;
			mem_q          <= '0;
			refr_q         <= '0;
		end else if (advance) begin
			held_current_q <= item_s1.current_in;
			syn_first_q    <= syn1_next;
			syn_second_q   <= syn2_next;
			mem_q          <= mem_next;
			refr_q         <= refr_next;
		end
	end

	// ---------------- assertions ----------------
	a_fire_reload: assert property (@(posedge clk) disable iff (!arst_n)
		advance && fire |=> refr_q == REFR_LOAD && mem_q == $past(reset_level_q))
		else $error("spike did not reload counter and membrane");

	a_refr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !refr_zero && !fire |=> mem_q == $past(mem_q)
			&& refr_q == $past(refr_q) - 1'b1)
		else $error("refractory tick changed membrane or miscounted");

	a_state_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> mem_q == $past(mem_q) && syn_first_q == $past(syn_first_q))
		else $error("neuron state moved without a tick");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> valid_s1 && result_valid_q && !result_ready)
		else $error("input stalled with room downstream");

endmodule
`default_nettype wire
